// ===== hw/rtl/crhk_pkg.sv =====
`default_nettype none

package crhk_pkg;

  // fixed field widths
  localparam int SEQ_W      = 32;
  localparam int COUNT_W    = 8;
  localparam int SLOT_W     = 8;
  localparam int INDEX_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // move packets are sent at least this many times unless an explicit hold cancels the move
  localparam logic [COUNT_W-1:0] MIN_REPEAT = COUNT_W'(3);

  // packet mode codes
  localparam logic MODE_HOLD = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_COUNT = 3'd0,
    CFG_SLOT_ID      = 3'd1,
    CFG_INIT_X       = 3'd2,
    CFG_INIT_Y       = 3'd3,
    CFG_INIT_Z       = 3'd4
  } cfg_reg_t;

  // flags of one request
  typedef struct packed {
    logic hold_req;
    logic cmd_valid;
    logic send_ok;
  } item_ctrl_t;

  // packet header fields produced per tick
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic               mode;
    logic [INDEX_W-1:0] rep_index;
    logic [COUNT_W-1:0] rep_total;
    logic               cmd_taken;
  } pkt_info_t;

  // sequence allocator step, zero is never handed out
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] n;
    n = s + SEQ_W'(1);
    return (n == '0) ? SEQ_W'(1) : n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/command_repeat_hold_keepalive.sv =====
`default_nettype none

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready   | hold request, hold position, command, send result
// out_    | output    | out_valid/out_ready | packet sequence, mode, position, slot, repeat info
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata (always ready)
//
// one request per clock sustained while out_ready holds; an accepted request goes
// into the input register, and the state update writes its packet to the result register
// the rate is set by the registered state update loop in crhk_tick
// synchronous active-low reset clears the control state and loads register defaults
// a stalled result holds in the output register while the input register takes
// the next request; the input side stalls only when both registers are full

module command_repeat_hold_keepalive import crhk_pkg::*; #(
  parameter int POSITION_WIDTH   = 32,
  parameter int HOLD_INDEX_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_hold_req,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_hold_x,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_hold_y,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_hold_z,
  input  wire logic                              in_cmd_valid,
  input  wire logic [SEQ_W-1:0]                  in_cmd_seq,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_cmd_x,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_cmd_y,
  input  wire logic signed [POSITION_WIDTH-1:0]  in_cmd_z,
  input  wire logic                              in_send_ok,
  // packet channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [SEQ_W-1:0]                       out_pkt_seq,
  output logic                                   out_pkt_mode,
  output logic signed [POSITION_WIDTH-1:0]       out_pkt_x,
  output logic signed [POSITION_WIDTH-1:0]       out_pkt_y,
  output logic signed [POSITION_WIDTH-1:0]       out_pkt_z,
  output logic [SLOT_W-1:0]                      out_pkt_slot,
  output logic [INDEX_W-1:0]                     out_pkt_repeat_index,
  output logic [COUNT_W-1:0]                     out_pkt_repeat_total,
  output logic                                   out_cmd_taken,
  // configuration channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]              cfg_index,
  input  wire logic [CFG_DATA_W-1:0]             cfg_wdata
);

  // configuration registers
  logic [COUNT_W-1:0]              repeat_count_r;
  logic [SLOT_W-1:0]               slot_id_r;
  logic [2:0][POSITION_WIDTH-1:0]  init_pos_r;

  // input register
  logic                            iv_r, iv_nxt;
  item_ctrl_t                      item_r;
  logic [2:0][POSITION_WIDTH-1:0]  hold_pos_r;
  logic [SEQ_W-1:0]                cmd_seq_r;
  logic [2:0][POSITION_WIDTH-1:0]  cmd_pos_r;

  // result register
  logic                            ov_r, ov_nxt;
  pkt_info_t                       pkt_r;
  logic [2:0][POSITION_WIDTH-1:0]  pkt_pos_r;
  logic [SLOT_W-1:0]               pkt_slot_r;

  logic                            in_fire;
  logic                            adv;
  pkt_info_t                       pkt;
  logic [2:0][POSITION_WIDTH-1:0]  pkt_pos;

  // handshake
  assign adv       = iv_r && (!ov_r || out_ready);
  assign in_ready  = !iv_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign iv_nxt    = in_fire ? 1'b1 : (adv ? 1'b0 : iv_r);
  assign ov_nxt    = adv ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_count_r <= MIN_REPEAT;
      slot_id_r      <= '0;
      init_pos_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REPEAT_COUNT: repeat_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_SLOT_ID:      slot_id_r      <= cfg_wdata[SLOT_W-1:0];
        CFG_INIT_X:       init_pos_r[0]  <= POSITION_WIDTH'(cfg_wdata);
        CFG_INIT_Y:       init_pos_r[1]  <= POSITION_WIDTH'(cfg_wdata);
        CFG_INIT_Z:       init_pos_r[2]  <= POSITION_WIDTH'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
      ov_r <= ov_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.hold_req  <= in_hold_req;
      item_r.cmd_valid <= in_cmd_valid;
      item_r.send_ok   <= in_send_ok;
      hold_pos_r       <= {in_hold_z, in_hold_y, in_hold_x};
      cmd_seq_r        <= in_cmd_seq;
      cmd_pos_r        <= {in_cmd_z, in_cmd_y, in_cmd_x};
    end
  end

  // per-tick state update
  crhk_tick #(
    .POSITION_WIDTH   (POSITION_WIDTH),
    .HOLD_INDEX_WIDTH (HOLD_INDEX_WIDTH)
  ) u_tick (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (adv),
    .item         (item_r),
    .hold_pos     (hold_pos_r),
    .cmd_seq      (cmd_seq_r),
    .cmd_pos      (cmd_pos_r),
    .repeat_count (repeat_count_r),
    .init_pos     (init_pos_r),
    .pkt          (pkt),
    .pkt_pos      (pkt_pos)
  );

  // result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pkt_r      <= pkt;
      pkt_pos_r  <= pkt_pos;
      pkt_slot_r <= slot_id_r;
    end
  end

  assign out_valid            = ov_r;
  assign out_pkt_seq          = pkt_r.seq;
  assign out_pkt_mode         = pkt_r.mode;
  assign out_pkt_x            = pkt_pos_r[0];
  assign out_pkt_y            = pkt_pos_r[1];
  assign out_pkt_z            = pkt_pos_r[2];
  assign out_pkt_slot         = pkt_slot_r;
  assign out_pkt_repeat_index = pkt_r.rep_index;
  assign out_pkt_repeat_total = pkt_r.rep_total;
  assign out_cmd_taken        = pkt_r.cmd_taken;

  // packets never carry sequence zero
  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> pkt_r.seq != '0)
    else $error("packet with sequence zero");

  // repeat total matches the packet mode
  a_total_mode: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (pkt_r.mode == MODE_MOVE && pkt_r.rep_total >= MIN_REPEAT) ||
             (pkt_r.mode == MODE_HOLD && pkt_r.rep_total == '0))
    else $error("repeat total does not match mode");

  // a pending request is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    iv_r && !adv |=> iv_r)
    else $error("pending request lost");

endmodule

`default_nettype wire

// ===== hw/rtl/crhk_tick.sv =====
`default_nettype none

module crhk_tick import crhk_pkg::*; #(
  parameter int POSITION_WIDTH   = 32,
  parameter int HOLD_INDEX_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 step_en,
  input  wire item_ctrl_t                           item,
  input  wire logic [2:0][POSITION_WIDTH-1:0]       hold_pos,
  input  wire logic [SEQ_W-1:0]                     cmd_seq,
  input  wire logic [2:0][POSITION_WIDTH-1:0]       cmd_pos,
  input  wire logic [COUNT_W-1:0]                   repeat_count,
  input  wire logic [2:0][POSITION_WIDTH-1:0]       init_pos,
  output pkt_info_t                                 pkt,
  output logic [2:0][POSITION_WIDTH-1:0]            pkt_pos
);

  localparam logic [HOLD_INDEX_WIDTH-1:0] HOLD_MAX = '1;

  // state registers
  logic                                 primed_r, primed_nxt;
  logic                                 move_active_r, move_active_nxt;
  logic [COUNT_W-1:0]                   sends_done_r, sends_done_nxt;
  logic [HOLD_INDEX_WIDTH-1:0]          hold_done_r, hold_done_nxt;
  logic [SEQ_W-1:0]                     next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]                     hold_seq_r, hold_seq_nxt;
  logic [SEQ_W-1:0]                     move_seq_r, move_seq_nxt;
  logic [2:0][POSITION_WIDTH-1:0]       last_pos_r, last_pos_nxt;
  logic [2:0][POSITION_WIDTH-1:0]       hold_pos_r, hold_pos_nxt;
  logic [2:0][POSITION_WIDTH-1:0]       move_pos_r, move_pos_nxt;

  logic [COUNT_W-1:0]                   total;
  logic [COUNT_W-1:0]                   sends_inc;

  // effective repeat total
  assign total = (repeat_count < MIN_REPEAT) ? MIN_REPEAT : repeat_count;

  // one tick: prime, explicit hold, command intake, packet, send result
  always_comb begin
    primed_nxt      = 1'b1;
    move_active_nxt = move_active_r;
    sends_done_nxt  = sends_done_r;
    hold_done_nxt   = hold_done_r;
    next_seq_nxt    = next_seq_r;
    hold_seq_nxt    = hold_seq_r;
    move_seq_nxt    = move_seq_r;
    last_pos_nxt    = last_pos_r;
    hold_pos_nxt    = hold_pos_r;
    move_pos_nxt    = move_pos_r;
    pkt             = '0;
    pkt_pos         = '0;
    sends_inc       = '0;

    // priming hold at the initial position
    if (!primed_r) begin
      last_pos_nxt  = init_pos;
      hold_seq_nxt  = next_seq_nxt;
      next_seq_nxt  = seq_inc(next_seq_nxt);
      hold_pos_nxt  = init_pos;
      hold_done_nxt = '0;
    end

    // explicit hold cancels any move
    if (item.hold_req) begin
      last_pos_nxt    = hold_pos;
      move_active_nxt = 1'b0;
      sends_done_nxt  = '0;
      hold_seq_nxt    = next_seq_nxt;
      next_seq_nxt    = seq_inc(next_seq_nxt);
      hold_pos_nxt    = hold_pos;
      hold_done_nxt   = '0;
    end

    // command intake when idle
    if (!move_active_nxt && item.cmd_valid) begin
      if (cmd_seq == '0) begin
        move_seq_nxt = next_seq_nxt;
        next_seq_nxt = seq_inc(next_seq_nxt);
      end else begin
        move_seq_nxt = cmd_seq;
      end
      move_pos_nxt    = cmd_pos;
      last_pos_nxt    = cmd_pos;
      move_active_nxt = 1'b1;
      sends_done_nxt  = '0;
      pkt.cmd_taken   = 1'b1;
    end

    // packet contents
    if (move_active_nxt) begin
      pkt.seq       = move_seq_nxt;
      pkt.mode      = MODE_MOVE;
      pkt_pos       = move_pos_nxt;
      pkt.rep_index = INDEX_W'(sends_done_nxt) + INDEX_W'(1);
      pkt.rep_total = total;
    end else begin
      if (hold_done_nxt == HOLD_MAX) begin
        hold_done_nxt = '0;
      end
      pkt.seq       = hold_seq_nxt;
      pkt.mode      = MODE_HOLD;
      pkt_pos       = hold_pos_nxt;
      pkt.rep_index = INDEX_W'(hold_done_nxt) + INDEX_W'(1);
      pkt.rep_total = '0;
    end

    // send result
    if (item.send_ok) begin
      if (move_active_nxt) begin
        sends_inc = sends_done_nxt + COUNT_W'(1);
        if (sends_inc >= total) begin
          move_active_nxt = 1'b0;
          sends_done_nxt  = '0;
          hold_seq_nxt    = next_seq_nxt;
          next_seq_nxt    = seq_inc(next_seq_nxt);
          hold_pos_nxt    = last_pos_nxt;
          hold_done_nxt   = '0;
        end else begin
          sends_done_nxt = sends_inc;
        end
      end else begin
        hold_done_nxt = hold_done_nxt + HOLD_INDEX_WIDTH'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r      <= 1'b0;
      move_active_r <= 1'b0;
      sends_done_r  <= '0;
      hold_done_r   <= '0;
      next_seq_r    <= SEQ_W'(1);
    end else if (step_en) begin
      primed_r      <= primed_nxt;
      move_active_r <= move_active_nxt;
      sends_done_r  <= sends_done_nxt;
      hold_done_r   <= hold_done_nxt;
      next_seq_r    <= next_seq_nxt;
    end
  end

  // sequence numbers and positions, always written before use
  always_ff @(posedge clk) begin
    if (step_en) begin
      hold_seq_r <= hold_seq_nxt;
      move_seq_r <= move_seq_nxt;
      last_pos_r <= last_pos_nxt;
      hold_pos_r <= hold_pos_nxt;
      move_pos_r <= move_pos_nxt;
    end
  end

  // allocator never holds zero
  a_next_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_seq_r != '0)
    else $error("allocator reached zero");

  // a move in flight never has its count at or past the total after a send
  a_move_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && move_active_nxt && item.send_ok |=> sends_done_r < total || !move_active_r)
    else $error("move outlived its repeat total");

  // a taken command always yields a move packet
  a_taken_move: assert property (@(posedge clk) disable iff (!rst_n)
    pkt.cmd_taken |-> pkt.mode == MODE_MOVE)
    else $error("taken command without move packet");

endmodule

`default_nettype wire

// ===== tb/sv/command_repeat_hold_keepalive_tb.sv =====
`default_nettype none

module command_repeat_hold_keepalive_tb;
  import crhk_pkg::*;

  localparam int POS_W = 32;
  localparam int HOLD_IDX_W = 32;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam int MAX_PRINTS = 100;

  // one heartbeat tick as offered on the request channel
  typedef struct {
    logic             hold_req;
    logic [POS_W-1:0] hold_x;
    logic [POS_W-1:0] hold_y;
    logic [POS_W-1:0] hold_z;
    logic             cmd_valid;
    logic [SEQ_W-1:0] cmd_seq;
    logic [POS_W-1:0] cmd_x;
    logic [POS_W-1:0] cmd_y;
    logic [POS_W-1:0] cmd_z;
    logic             send_ok;
  } tick_t;

  // one control packet on the result channel
  typedef struct {
    logic [SEQ_W-1:0]   seq;
    logic               mode;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [SLOT_W-1:0]  slot;
    logic [INDEX_W-1:0] rep_idx;
    logic [COUNT_W-1:0] rep_total;
    logic               taken;
  } pkt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_hold_req = 1'b0;
  logic [POS_W-1:0] in_hold_x = '0;
  logic [POS_W-1:0] in_hold_y = '0;
  logic [POS_W-1:0] in_hold_z = '0;
  logic             in_cmd_valid = 1'b0;
  logic [SEQ_W-1:0] in_cmd_seq = '0;
  logic [POS_W-1:0] in_cmd_x = '0;
  logic [POS_W-1:0] in_cmd_y = '0;
  logic [POS_W-1:0] in_cmd_z = '0;
  logic             in_send_ok = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SEQ_W-1:0]   out_pkt_seq;
  logic               out_pkt_mode;
  logic [POS_W-1:0]   out_pkt_x;
  logic [POS_W-1:0]   out_pkt_y;
  logic [POS_W-1:0]   out_pkt_z;
  logic [SLOT_W-1:0]  out_pkt_slot;
  logic [INDEX_W-1:0] out_pkt_repeat_index;
  logic [COUNT_W-1:0] out_pkt_repeat_total;
  logic               out_cmd_taken;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  command_repeat_hold_keepalive #(
    .POSITION_WIDTH  (POS_W),
    .HOLD_INDEX_WIDTH(HOLD_IDX_W)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_hold_req         (in_hold_req),
    .in_hold_x           (in_hold_x),
    .in_hold_y           (in_hold_y),
    .in_hold_z           (in_hold_z),
    .in_cmd_valid        (in_cmd_valid),
    .in_cmd_seq          (in_cmd_seq),
    .in_cmd_x            (in_cmd_x),
    .in_cmd_y            (in_cmd_y),
    .in_cmd_z            (in_cmd_z),
    .in_send_ok          (in_send_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pkt_seq         (out_pkt_seq),
    .out_pkt_mode        (out_pkt_mode),
    .out_pkt_x           (out_pkt_x),
    .out_pkt_y           (out_pkt_y),
    .out_pkt_z           (out_pkt_z),
    .out_pkt_slot        (out_pkt_slot),
    .out_pkt_repeat_index(out_pkt_repeat_index),
    .out_pkt_repeat_total(out_pkt_repeat_total),
    .out_cmd_taken       (out_cmd_taken),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // clock
  always begin
    #6 clk = ~clk;
  end

  // predictor copy of the configuration
  logic [COUNT_W-1:0] repeat_cfg = COUNT_W'(3);
  logic [SLOT_W-1:0]  slot_cfg = '0;
  logic [POS_W-1:0]   init_pos [3] = '{default: '0};

  // predictor copy of the keepalive state
  logic               primed = 1'b0;
  logic [SEQ_W-1:0]   next_seq = SEQ_W'(1);
  logic [POS_W-1:0]   last_pos [3] = '{default: '0};
  logic [SEQ_W-1:0]   hold_seq = '0;
  logic [POS_W-1:0]   hold_pos [3] = '{default: '0};
  logic               move_active = 1'b0;
  logic [SEQ_W-1:0]   move_seq = '0;
  logic [POS_W-1:0]   move_pos [3] = '{default: '0};
  logic [COUNT_W-1:0] move_sends = '0;
  logic [INDEX_W-1:0] hold_reps = '0;

  tick_t tick_pending [$];
  pkt_t  pkt_expected [$];
  tick_t tick_driven;
  int    ticks_total = 0;
  int    ticks_taken = 0;
  int    pkts_seen = 0;
  int    errors = 0;

  // sequence allocator, never hands out zero
  function automatic logic [SEQ_W-1:0] claim_sequence();
    logic [SEQ_W-1:0] s;
    s = next_seq;
    next_seq = next_seq + SEQ_W'(1);
    if (next_seq == '0) next_seq = SEQ_W'(1);
    return s;
  endfunction

  // fresh hold at the last known position
  function automatic void open_hold();
    hold_seq = claim_sequence();
    hold_pos = last_pos;
    hold_reps = '0;
  endfunction

  // advance the predictor by one tick and form the packet it sends
  task automatic predict_packet(input tick_t t, output pkt_t p);
    logic [COUNT_W-1:0] total;
    logic               taken;
    total = (repeat_cfg < MIN_REPEAT) ? MIN_REPEAT : repeat_cfg;
    taken = 1'b0;
    if (!primed) begin
      primed = 1'b1;
      last_pos = init_pos;
      open_hold();
    end
    // explicit hold cancels any move
    if (t.hold_req) begin
      last_pos[0] = t.hold_x;
      last_pos[1] = t.hold_y;
      last_pos[2] = t.hold_z;
      move_active = 1'b0;
      move_sends = '0;
      open_hold();
    end
    // command intake only while no move runs
    if (!move_active && t.cmd_valid) begin
      move_seq = (t.cmd_seq == '0) ? claim_sequence() : t.cmd_seq;
      move_pos[0] = t.cmd_x;
      move_pos[1] = t.cmd_y;
      move_pos[2] = t.cmd_z;
      last_pos = move_pos;
      move_active = 1'b1;
      move_sends = '0;
      taken = 1'b1;
    end
    if (move_active) begin
      p.seq = move_seq;
      p.mode = MODE_MOVE;
      p.x = move_pos[0];
      p.y = move_pos[1];
      p.z = move_pos[2];
      p.rep_idx = INDEX_W'(move_sends) + INDEX_W'(1);
      p.rep_total = total;
    end else begin
      if (hold_reps == '1) hold_reps = '0;
      p.seq = hold_seq;
      p.mode = MODE_HOLD;
      p.x = hold_pos[0];
      p.y = hold_pos[1];
      p.z = hold_pos[2];
      p.rep_idx = hold_reps + INDEX_W'(1);
      p.rep_total = '0;
    end
    p.slot = slot_cfg;
    p.taken = taken;
    // send result advances the counters
    if (t.send_ok) begin
      if (move_active) begin
        move_sends = move_sends + COUNT_W'(1);
        if (move_sends >= total) begin
          move_active = 1'b0;
          move_sends = '0;
          open_hold();
        end
      end else begin
        hold_reps = hold_reps + INDEX_W'(1);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("packet %0d: %s got %h want %h", pkts_seen, what, got, want);
    errors++;
  endtask

  function automatic tick_t mk_tick(input logic hr, input logic [POS_W-1:0] hx,
                                    input logic [POS_W-1:0] hy, input logic [POS_W-1:0] hz,
                                    input logic cv, input logic [SEQ_W-1:0] cs,
                                    input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                                    input logic [POS_W-1:0] cz, input logic ok);
    tick_t t;
    t.hold_req = hr;
    t.hold_x = hx;
    t.hold_y = hy;
    t.hold_z = hz;
    t.cmd_valid = cv;
    t.cmd_seq = cs;
    t.cmd_x = cx;
    t.cmd_y = cy;
    t.cmd_z = cz;
    t.send_ok = ok;
    return t;
  endfunction

  // random position, sometimes an extreme bit pattern
  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      3: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic tick_t rand_tick(input int hold_pct, input int ok_pct);
    tick_t t;
    int    r;
    t.hold_req = ($urandom_range(99) < hold_pct);
    t.hold_x = rand_pos();
    t.hold_y = rand_pos();
    t.hold_z = rand_pos();
    t.cmd_valid = ($urandom_range(99) < 55);
    r = $urandom_range(99);
    if (r < 40) t.cmd_seq = '0;
    else if (r < 45) t.cmd_seq = '1;
    else t.cmd_seq = $urandom;
    t.cmd_x = rand_pos();
    t.cmd_y = rand_pos();
    t.cmd_z = rand_pos();
    t.send_ok = ($urandom_range(99) < ok_pct);
    return t;
  endfunction

  // register write, called at a clock edge; valid stays high for back-to-back writes
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REPEAT_COUNT: repeat_cfg = data[COUNT_W-1:0];
      CFG_SLOT_ID:      slot_cfg = data[SLOT_W-1:0];
      CFG_INIT_X:       init_pos[0] = data[POS_W-1:0];
      CFG_INIT_Y:       init_pos[1] = data[POS_W-1:0];
      CFG_INIT_Z:       init_pos[2] = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_random(input int hold_pct, input int ok_pct, input int n);
    for (int i = 0; i < n; i++) begin
      tick_pending.push_back(rand_tick(hold_pct, ok_pct));
      ticks_total++;
    end
  endtask

  // wait for every queued request to come back as a packet
  task automatic drain();
    while (pkts_seen < ticks_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] rpt, input logic [7:0] slot,
                           input int hold_pct, input int ok_pct, input int n);
    cfg_write(CFG_REPEAT_COUNT, CFG_DATA_W'(rpt));
    cfg_write(CFG_SLOT_ID, CFG_DATA_W'(slot));
    cfg_valid <= 1'b0;
    queue_random(hold_pct, ok_pct, n);
    drain();
  endtask

  // request driver
  always @(posedge clk) begin : driver
    pkt_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_packet(tick_driven, p);
        pkt_expected.push_back(p);
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tick_pending.size() > 0 &&
            ((ticks_taken >= 650 && ticks_taken < 900) || $urandom_range(99) >= 27)) begin
          tick_driven = tick_pending.pop_front();
          in_valid <= 1'b1;
          in_hold_req <= tick_driven.hold_req;
          in_hold_x <= tick_driven.hold_x;
          in_hold_y <= tick_driven.hold_y;
          in_hold_z <= tick_driven.hold_z;
          in_cmd_valid <= tick_driven.cmd_valid;
          in_cmd_seq <= tick_driven.cmd_seq;
          in_cmd_x <= tick_driven.cmd_x;
          in_cmd_y <= tick_driven.cmd_y;
          in_cmd_z <= tick_driven.cmd_z;
          in_send_ok <= tick_driven.send_ok;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // packet monitor and checker
  always @(posedge clk) begin : monitor
    pkt_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pkts_seen++;
        if (pkt_expected.size() == 0) begin
          report_mismatch("unexpected packet seq", out_pkt_seq, '0);
        end else begin
          want = pkt_expected.pop_front();
          if (out_pkt_seq !== want.seq)
            report_mismatch("pkt_seq", out_pkt_seq, want.seq);
          if (out_pkt_mode !== want.mode)
            report_mismatch("pkt_mode", 32'(out_pkt_mode), 32'(want.mode));
          if (out_pkt_x !== want.x)
            report_mismatch("pkt_x", out_pkt_x, want.x);
          if (out_pkt_y !== want.y)
            report_mismatch("pkt_y", out_pkt_y, want.y);
          if (out_pkt_z !== want.z)
            report_mismatch("pkt_z", out_pkt_z, want.z);
          if (out_pkt_slot !== want.slot)
            report_mismatch("pkt_slot", 32'(out_pkt_slot), 32'(want.slot));
          if (out_pkt_repeat_index !== want.rep_idx)
            report_mismatch("pkt_repeat_index", out_pkt_repeat_index, want.rep_idx);
          if (out_pkt_repeat_total !== want.rep_total)
            report_mismatch("pkt_repeat_total", 32'(out_pkt_repeat_total),
                            32'(want.rep_total));
          if (out_cmd_taken !== want.taken)
            report_mismatch("cmd_taken", 32'(out_cmd_taken), 32'(want.taken));
        end
      end
      out_ready <= (pkts_seen >= 650 && pkts_seen < 900) || ($urandom_range(99) >= 27);
    end
  end

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first setting: repeat count below the minimum, extreme slot, extreme start x and y
    cfg_write(CFG_REPEAT_COUNT, CFG_DATA_W'(0));
    cfg_write(CFG_SLOT_ID, CFG_DATA_W'(255));
    cfg_write(CFG_INIT_X, POS_MIN);
    cfg_write(CFG_INIT_Y, POS_MAX);
    cfg_write(CFG_INIT_Z, $urandom);
    cfg_valid <= 1'b0;

    // hold request on the very first tick
    tick_pending.push_back(mk_tick(1'b1, POS_MAX, POS_MIN, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    // failed send repeats the hold, then a good one
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    // command with zero sequence gets an allocated number
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '0, POS_MIN, POS_MAX, '1, 1'b1));
    // command while the move runs is not taken
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '1, POS_MAX, POS_MAX, POS_MAX,
                                   1'b0));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    // move done, hold at the move target
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    // explicit all-ones sequence
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '1, '0, '0, POS_MIN, 1'b1));
    // hold and command on one tick
    tick_pending.push_back(mk_tick(1'b1, '1, '0, POS_MAX, 1'b1, '0, POS_MAX, '0, POS_MIN,
                                   1'b1));
    // hold cancels an active move
    tick_pending.push_back(mk_tick(1'b1, POS_MIN, POS_MIN, POS_MIN, 1'b0, '0, '0, '0, '0,
                                   1'b0));
    tick_pending.push_back(mk_tick(1'b1, POS_MAX, '1, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, SEQ_W'(1), '1, '1, '1, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '0, POS_MIN, '1, POS_MAX, 1'b1));
    tick_pending.push_back(mk_tick(1'b0, '0, '0, '0, 1'b1, '0, '0, '0, '0, 1'b1));
    ticks_total += 20;
    queue_random(8, 80, 150);
    drain();

    // later settings; the long move phase usually leaves a move open for the next
    run_phase(8'd3, 8'd0, 10, 75, 200);
    run_phase(8'd255, 8'($urandom), 0, 95, 330);
    run_phase(8'd1, 8'($urandom), 8, 80, 150);
    run_phase(8'd2, 8'($urandom), 15, 60, 150);
    cfg_write(CFG_INIT_X, $urandom);
    cfg_write(CFG_INIT_Y, $urandom);
    cfg_write(CFG_INIT_Z, '0);
    run_phase(8'($urandom_range(12, 3)), 8'($urandom), 8, 85, 270);

    repeat (8) @(posedge clk);
    if (pkt_expected.size() != 0)
      report_mismatch("packets never seen", 32'(pkt_expected.size()), '0);
    if (errors == 0) begin
      $display("** command_repeat_hold_keepalive: PASSED **");
    end else begin
      $display("** command_repeat_hold_keepalive: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2400000;
    $display("** command_repeat_hold_keepalive: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
